[rtl/tsr_pkg.sv]
package tsr_pkg;

    localparam int BUF_DEPTH = 4096;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = BUF_AW + 1;
    localparam int CAP_W     = 13;
    localparam int POS_W     = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [POS_W-1:0] res;
        logic             borrow;
        logic             zero;
    } alu_rsp_t;

endpackage

[rtl/tsr_alu.sv]
module tsr_alu (
    input  tsr_pkg::alu_req_t req,
    output tsr_pkg::alu_rsp_t rsp
);
    import tsr_pkg::*;

    logic [POS_W:0] sum;

    always_comb
    begin
        case (req.op)
            ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
            default: sum = '0;
        endcase
    end

    assign rsp.res    = sum[POS_W-1:0];
    assign rsp.borrow = (req.op == ALU_SUB) && sum[POS_W];
    assign rsp.zero   = (sum[POS_W-1:0] == '0);

endmodule

[rtl/tcp_stream_reassembler_top.sv]
// A byte item passes S_WIN_LO, S_WIN_HI and S_STORE; a read passes S_RD_CMP and, unless
// nothing is assembled, S_RD_OUT. A segment-closing byte or an empty segment then reaches
// S_ASM_RD; S_ASM_CHK runs once per byte assembled and once more, then S_EOF with eof and
// S_END, all through one shared 64-bit adder. One item at a time; busy stays high until
// the done strobe. Reset: asynchronous, active low; a clearing pass then sweeps the slot
// store, one entry per cycle, with busy high. Configuration writes are taken anytime.
// The receiver cannot stall: each result is shown for one cycle with done.
module tcp_stream_reassembler_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [tsr_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      start,
    output logic                      busy,
    input  logic                      command,
    input  logic [tsr_pkg::POS_W-1:0] stream_index,
    input  logic [7:0]                data_byte,
    input  logic                      segment_last,
    input  logic                      segment_eof,
    input  logic                      segment_empty,
    output logic                      done,
    output logic [7:0]                read_byte,
    output logic                      read_valid,
    output logic                      byte_stored,
    output logic [tsr_pkg::CAP_W-1:0] pending_count,
    output logic [tsr_pkg::CAP_W-1:0] buffered_count,
    output logic                      stream_ended
);
    import tsr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WIN_LO,
        S_WIN_HI,
        S_STORE,
        S_ASM_RD,
        S_ASM_CHK,
        S_EOF,
        S_END,
        S_RD_CMP,
        S_RD_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [BUF_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              cmd_reg, cmd_next;
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic [7:0]        data_reg, data_next;
    logic              last_reg, last_next;
    logic              eof_reg, eof_next;
    logic              empty_reg, empty_next;
    logic              inwin_reg, inwin_next;
    logic [POS_W-1:0]  reader_reg, reader_next;
    logic [POS_W-1:0]  asm_reg, asm_next;
    logic [POS_W-1:0]  final_reg, final_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic              eof_seen_reg, eof_seen_next;
    logic              ended_reg, ended_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              done_reg, done_next;
    logic [7:0]        rbyte_reg, rbyte_next;
    logic              rvalid_reg, rvalid_next;
    logic              stored_reg, stored_next;

    logic [8:0]        mem [BUF_DEPTH];
    logic [8:0]        mem_rdata_reg;
    logic              mem_we;
    logic [BUF_AW-1:0] mem_waddr;
    logic [8:0]        mem_wdata;
    logic [BUF_AW-1:0] mem_raddr;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    tsr_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        eof_next      = eof_reg;
        empty_next    = empty_reg;
        inwin_next    = inwin_reg;
        reader_next   = reader_reg;
        asm_next      = asm_reg;
        final_next    = final_reg;
        pend_next     = pend_reg;
        eof_seen_next = eof_seen_reg;
        ended_next    = ended_reg;
        done_next     = 1'b0;
        rbyte_next    = rbyte_reg;
        rvalid_next   = rvalid_reg;
        stored_next   = stored_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[BUF_AW-1:0];
        mem_wdata     = {1'b1, data_reg};
        mem_raddr     = idx_reg[BUF_AW-1:0];
        alu_req.op    = ALU_SUB;
        alu_req.a     = asm_reg;
        alu_req.b     = reader_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = command;
                    idx_next    = stream_index;
                    data_next   = data_byte;
                    last_next   = segment_last;
                    eof_next    = segment_eof;
                    empty_next  = segment_empty;
                    rbyte_next  = '0;
                    rvalid_next = 1'b0;
                    stored_next = 1'b0;
                    if (command)
                    begin
                        state_next = S_RD_CMP;
                    end
                    else if (segment_empty)
                    begin
                        state_next = S_ASM_RD;
                    end
                    else
                    begin
                        state_next = S_WIN_LO;
                    end
                end
            end
            S_WIN_LO:
            begin
                alu_req.a  = idx_reg;
                alu_req.b  = asm_reg;
                inwin_next = !alu_rsp.borrow;
                state_next = S_WIN_HI;
            end
            S_WIN_HI:
            begin
                alu_req.a  = idx_reg;
                alu_req.b  = reader_reg;
                inwin_next = inwin_reg
                             && (alu_rsp.res[POS_W-1:CAP_W] == '0)
                             && (alu_rsp.res[CAP_W-1:0] < cap_reg)
                             && (alu_rsp.res < POS_W'(BUF_DEPTH));
                state_next = S_STORE;
            end
            S_STORE:
            begin
                if (inwin_reg && !mem_rdata_reg[8])
                begin
                    mem_we      = 1'b1;
                    pend_next   = pend_reg + 1'b1;
                    stored_next = 1'b1;
                end
                if (last_reg)
                begin
                    state_next = S_ASM_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_ASM_RD:
            begin
                mem_raddr  = asm_reg[BUF_AW-1:0];
                state_next = S_ASM_CHK;
            end
            S_ASM_CHK:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = asm_reg;
                alu_req.b  = POS_W'(1);
                mem_raddr  = asm_reg[BUF_AW-1:0] + 1'b1;
                if (mem_rdata_reg[8])
                begin
                    mem_we    = 1'b1;
                    mem_waddr = asm_reg[BUF_AW-1:0];
                    mem_wdata = {1'b0, mem_rdata_reg[7:0]};
                    asm_next  = alu_rsp.res;
                    if (pend_reg != '0)
                    begin
                        pend_next = pend_reg - 1'b1;
                    end
                end
                else if (eof_reg)
                begin
                    state_next = S_EOF;
                end
                else
                begin
                    state_next = S_END;
                end
            end
            S_EOF:
            begin
                alu_req.op    = ALU_ADD;
                alu_req.a     = idx_reg;
                alu_req.b     = POS_W'(!empty_reg);
                final_next    = alu_rsp.res;
                eof_seen_next = 1'b1;
                state_next    = S_END;
            end
            S_END:
            begin
                alu_req.a = asm_reg;
                alu_req.b = final_reg;
                if (eof_seen_reg && alu_rsp.zero)
                begin
                    ended_next = 1'b1;
                end
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_RD_CMP:
            begin
                mem_raddr = reader_reg[BUF_AW-1:0];
                if (alu_rsp.zero)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_RD_OUT;
                end
            end
            S_RD_OUT:
            begin
                alu_req.op  = ALU_ADD;
                alu_req.a   = reader_reg;
                alu_req.b   = POS_W'(1);
                reader_next = alu_rsp.res;
                rbyte_next  = mem_rdata_reg[7:0];
                rvalid_next = 1'b1;
                state_next  = S_IDLE;
                done_next   = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            reader_reg   <= '0;
            asm_reg      <= '0;
            final_reg    <= '0;
            pend_reg     <= '0;
            eof_seen_reg <= 1'b0;
            ended_reg    <= 1'b0;
            done_reg     <= 1'b0;
            rbyte_reg    <= '0;
            rvalid_reg   <= 1'b0;
            stored_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            reader_reg   <= reader_next;
            asm_reg      <= asm_next;
            final_reg    <= final_next;
            pend_reg     <= pend_next;
            eof_seen_reg <= eof_seen_next;
            ended_reg    <= ended_next;
            done_reg     <= done_next;
            rbyte_reg    <= rbyte_next;
            rvalid_reg   <= rvalid_next;
            stored_reg   <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        data_reg  <= data_next;
        last_reg  <= last_next;
        eof_reg   <= eof_next;
        empty_reg <= empty_next;
        inwin_reg <= inwin_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign read_byte      = rbyte_reg;
    assign read_valid     = rvalid_reg && cmd_reg;
    assign byte_stored    = stored_reg;
    assign pending_count  = CAP_W'(pend_reg);
    assign buffered_count = asm_reg[CAP_W-1:0] - reader_reg[CAP_W-1:0];
    assign stream_ended   = ended_reg;

endmodule

[rtl/tsr_checker.sv]
module tsr_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic read_valid,
    input logic byte_stored,
    input logic stream_ended
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_read_or_store: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(read_valid && byte_stored))
        else $error("read and store reported on one beat");

    a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(stream_ended) |-> stream_ended)
        else $error("stream_ended dropped");

endmodule

bind tcp_stream_reassembler_top tsr_checker u_tsr_checker (.*);

[tb/reasm_check_pkg.sv]
package reasm_check_pkg;

    import tsr_pkg::*;

    typedef enum bit {
        CMD_SEGMENT = 1'b0,
        CMD_READ    = 1'b1
    } command_t;

    typedef struct packed {
        command_t         command;
        logic [POS_W-1:0] index;
        logic [7:0]       data;
        logic             last;
        logic             eof;
        logic             empty;
    } reasm_beat_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             read_valid;
        logic             byte_stored;
        logic [CAP_W-1:0] pending_count;
        logic [CAP_W-1:0] buffered_count;
        logic             stream_ended;
    } reasm_resp_t;

    class stream_scoreboard_t;
        logic [7:0]       held_byte [BUF_DEPTH];
        bit               slot_held [BUF_DEPTH];
        logic [POS_W-1:0] reader_pos;
        logic [POS_W-1:0] assembled_pos;
        logic [POS_W-1:0] final_pos;
        int unsigned      pending;
        bit               eof_seen;
        bit               ended;
        logic [CAP_W-1:0] capacity;
        reasm_resp_t      due [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      stored_total;
        int unsigned      reads_hit;

        function new();
            foreach (held_byte[i])
            begin
                held_byte[i] = '0;
                slot_held[i] = 1'b0;
            end
            reader_pos    = '0;
            assembled_pos = '0;
            final_pos     = '0;
            pending       = 0;
            eof_seen      = 1'b0;
            ended         = 1'b0;
            capacity      = CAP_RESET;
            errors        = 0;
            checked       = 0;
            stored_total  = 0;
            reads_hit     = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned window_limit();
            if (capacity > BUF_DEPTH)
                return BUF_DEPTH;
            return int'(capacity);
        endfunction

        function int unsigned outstanding();
            return due.size();
        endfunction

        function void accept_beat(reasm_beat_t b);
            reasm_resp_t      r;
            logic [POS_W-1:0] room;
            r    = '0;
            room = POS_W'(window_limit());
            if (b.command == CMD_READ)
            begin
                if (assembled_pos != reader_pos)
                begin
                    r.read_byte  = held_byte[reader_pos[BUF_AW-1:0]];
                    r.read_valid = 1'b1;
                    reader_pos++;
                    reads_hit++;
                end
            end
            else
            begin
                if (!b.empty && b.index >= assembled_pos && (b.index - reader_pos) < room)
                begin
                    if (!slot_held[b.index[BUF_AW-1:0]])
                    begin
                        slot_held[b.index[BUF_AW-1:0]] = 1'b1;
                        held_byte[b.index[BUF_AW-1:0]] = b.data;
                        pending++;
                        r.byte_stored = 1'b1;
                        stored_total++;
                    end
                end
                if (b.last || b.empty)
                begin
                    while (slot_held[assembled_pos[BUF_AW-1:0]])
                    begin
                        slot_held[assembled_pos[BUF_AW-1:0]] = 1'b0;
                        assembled_pos++;
                        if (pending > 0)
                            pending--;
                    end
                    if (b.eof)
                    begin
                        eof_seen  = 1'b1;
                        final_pos = b.empty ? b.index : b.index + 1'b1;
                    end
                    if (eof_seen && assembled_pos == final_pos)
                        ended = 1'b1;
                end
            end
            r.pending_count  = pending[CAP_W-1:0];
            r.buffered_count = CAP_W'(assembled_pos - reader_pos);
            r.stream_ended   = ended;
            due.push_back(r);
        endfunction

        function void check_response(reasm_resp_t got);
            reasm_resp_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display(
                "tb: result with no beat outstanding: byte %02h valid %b stored %b",
                             got.read_byte, got.read_valid, got.byte_stored);
                return;
            end
            want = due[0];
            due.delete(0);
            checked++;
            if (got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
                got.byte_stored !== want.byte_stored ||
                got.pending_count !== want.pending_count ||
                got.buffered_count !== want.buffered_count ||
                got.stream_ended !== want.stream_ended)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("tb: mismatch on result %0d (expected/actual): byte %02h/%02h",
                             checked, want.read_byte, got.read_byte);
                    $display("tb:   valid %b/%b stored %b/%b ended %b/%b",
                             want.read_valid, got.read_valid,
                             want.byte_stored, got.byte_stored,
                             want.stream_ended, got.stream_ended);
                    $display("tb:   pending %0d/%0d buffered %0d/%0d",
                             want.pending_count, got.pending_count,
                             want.buffered_count, got.buffered_count);
                end
            end
        endfunction
    endclass

endpackage

[tb/tcp_stream_reassembler_top_test.sv]
module tcp_stream_reassembler_top_test;

    import tsr_pkg::*;
    import reasm_check_pkg::*;

    localparam int QUIET_LIMIT = 50000;
    localparam int PHASE_BEATS = 290;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    logic             start;
    logic             busy;
    logic             command;
    logic [POS_W-1:0] stream_index;
    logic [7:0]       data_byte;
    logic             segment_last;
    logic             segment_eof;
    logic             segment_empty;
    logic             done;
    logic [7:0]       read_byte;
    logic             read_valid;
    logic             byte_stored;
    logic [CAP_W-1:0] pending_count;
    logic [CAP_W-1:0] buffered_count;
    logic             stream_ended;

    stream_scoreboard_t sb;
    reasm_resp_t      seen;
    bit               gaps_on;
    int unsigned      beats_sent;
    int unsigned      settings_used;

    tcp_stream_reassembler_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .stream_index   (stream_index),
        .data_byte      (data_byte),
        .segment_last   (segment_last),
        .segment_eof    (segment_eof),
        .segment_empty  (segment_empty),
        .done           (done),
        .read_byte      (read_byte),
        .read_valid     (read_valid),
        .byte_stored    (byte_stored),
        .pending_count  (pending_count),
        .buffered_count (buffered_count),
        .stream_ended   (stream_ended)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen.read_byte      = read_byte;
            seen.read_valid     = read_valid;
            seen.byte_stored    = byte_stored;
            seen.pending_count  = pending_count;
            seen.buffered_count = buffered_count;
            seen.stream_ended   = stream_ended;
            sb.check_response(seen);
        end
    end

    function automatic reasm_beat_t mk_beat(command_t c, logic [POS_W-1:0] idx,
                                            logic [7:0] d, bit last, bit eof, bit empty);
        reasm_beat_t b;
        b.command = c;
        b.index   = idx;
        b.data    = d;
        b.last    = last;
        b.eof     = eof;
        b.empty   = empty;
        return b;
    endfunction

    task automatic send_beat(input reasm_beat_t b);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 28)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        command       = b.command;
        stream_index  = b.index;
        data_byte     = b.data;
        segment_last  = b.last;
        segment_eof   = b.eof;
        segment_empty = b.empty;
        start         = 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.accept_beat(b);
        beats_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (sb.outstanding() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_capacity(value);
        settings_used++;
    endtask

    task automatic send_segment();
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] pos;
        logic [7:0]       d;
        int unsigned      room;
        int unsigned      len;
        bit               at_eof;
        room = sb.window_limit();
        if ($urandom_range(0, 19) == 0)
            base = sb.reader_pos + room - $urandom_range(0, 3);
        else
            base = sb.assembled_pos - $urandom_range(0, 4) +
                   $urandom_range(0, (room < 40 ? room : 40) + 4);
        len    = $urandom_range(1, 10);
        at_eof = $urandom_range(0, 99) < 4;
        for (int k = 0; k < len; k++)
        begin
            pos = base + k;
            if ($urandom_range(0, 4) == 0)
                d = 8'($urandom_range(0, 255));
            else
                d = pos[7:0] ^ pos[15:8];
            send_beat(mk_beat(CMD_SEGMENT, pos, d, k == len - 1,
                              (k == len - 1) ? at_eof : bit'($urandom_range(0, 1)), 1'b0));
        end
    endtask

    task automatic send_reads();
        int unsigned n;
        if (sb.assembled_pos - sb.reader_pos > 32)
            n = $urandom_range(4, 12);
        else
            n = $urandom_range(1, 6);
        repeat (n)
            send_beat(mk_beat(CMD_READ, {$urandom(), $urandom()},
                              8'($urandom_range(0, 255)),
                              bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
                              bit'($urandom_range(0, 1))));
    endtask

    task automatic run_phase(input int unsigned beats);
        int unsigned goal;
        int unsigned pick;
        goal = beats_sent + beats;
        while (beats_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_segment();
            else if (pick < 80)
                send_reads();
            else if (pick < 90)
                send_beat(mk_beat(CMD_SEGMENT, sb.assembled_pos + $urandom_range(0, 8) - 4,
                                  8'($urandom_range(0, 255)), bit'($urandom_range(0, 1)),
                                  $urandom_range(0, 99) < 40, 1'b1));
            else
                send_beat(mk_beat(command_t'($urandom_range(0, 1)), {$urandom(), $urandom()},
                                  8'($urandom_range(0, 255)), bit'($urandom_range(0, 1)),
                                  bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1))));
        end
    endtask

    task automatic run_directed();
        send_beat(mk_beat(CMD_READ, '0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd0, 8'hA5, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd0, 8'h5A, 1'b1, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd0, 8'hFF, 1'b1, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd4095, 8'h00, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd4096, 8'hFF, 1'b0, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd2, 8'h3C, 1'b1, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd1, 8'hC3, 1'b0, 1'b1, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd50, 8'h77, 1'b0, 1'b0, 1'b1));
        repeat (4)
            send_beat(mk_beat(CMD_READ, '1, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_beat(mk_beat(CMD_SEGMENT, 64'd100, 8'h00, 1'b0, 1'b1, 1'b1));
        send_beat(mk_beat(CMD_SEGMENT, '1, 8'hFF, 1'b1, 1'b1, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'h8000_0000_0000_0000, 8'h00, 1'b1, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_SEGMENT, 64'd3, 8'h81, 1'b1, 1'b0, 1'b0));
        send_beat(mk_beat(CMD_READ, '0, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: nothing accepted for %0d cycles", quiet);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] setting;
        sb            = new();
        gaps_on       = 1'b1;
        beats_sent    = 0;
        settings_used = 0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        start         = 1'b0;
        command       = 1'b0;
        stream_index  = '0;
        data_byte     = '0;
        segment_last  = 1'b0;
        segment_eof   = 1'b0;
        segment_empty = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        for (int p = 0; p < 7; p++)
        begin
            // hold off the sender until every response is back, then retune the window
            settle();
            case (p)
                0: setting = 13'd8191;
                1: setting = 13'd0;
                2: setting = 13'd1;
                3: setting = 13'd4096;
                4: setting = 13'd16;
                5: setting = 13'd4097;
                default: setting = CAP_W'($urandom_range(2, 4095));
            endcase
            write_capacity(setting);
            gaps_on = (p != 3);
            run_phase(PHASE_BEATS);
        end
        settle();

        $display("tb: %0d beats sent, %0d responses checked across %0d window settings",
                 beats_sent, sb.checked, settings_used);
        $display("tb: %0d bytes kept, %0d reads returned data, end of stream reached: %0d",
                 sb.stored_total, sb.reads_hit, sb.ended);
        if (sb.outstanding() != 0)
            $display("tb: %0d responses never arrived", sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/tsr_pkg.sv
rtl/tsr_alu.sv
rtl/tcp_stream_reassembler_top.sv
rtl/tsr_checker.sv
tb/reasm_check_pkg.sv
tb/tcp_stream_reassembler_top_test.sv
